// ===== design/sbpp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpp_pkg
// shared types and constants for the six-button pad poller
// ----------------------------------------------------------------------------
`default_nettype none

package sbpp_pkg;

  localparam int unsigned WORD_W = 13;

  // button word bit positions
  localparam int unsigned BTN_UP    = 0;
  localparam int unsigned BTN_DOWN  = 1;
  localparam int unsigned BTN_LEFT  = 2;
  localparam int unsigned BTN_RIGHT = 3;
  localparam int unsigned BTN_A     = 4;
  localparam int unsigned BTN_B     = 5;
  localparam int unsigned BTN_C     = 6;
  localparam int unsigned BTN_START = 7;
  localparam int unsigned BTN_X     = 8;
  localparam int unsigned BTN_Y     = 9;
  localparam int unsigned BTN_Z     = 10;
  localparam int unsigned BTN_MODE  = 11;
  localparam int unsigned BTN_HOME  = 12;

  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_POLLS = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // sampled pin levels, 0 = low = active
  typedef struct packed {
    logic pin1;
    logic pin2;
    logic pin3;
    logic pin4;
    logic pin6;
    logic pin9;
  } pins_t;

  typedef struct packed {
    logic       select_level;
    logic       pad_connected;
    logic       six_mode;
    logic [1:0] skip_count;
    word_t      button_word;
  } state_t;

endpackage

`default_nettype wire

// ===== design/six_button_pad_poller.sv =====
// ----------------------------------------------------------------------------
// six_button_pad_poller
// an accepted poll request has its result in the output register in the
//   next cycle; throughput: one poll request per cycle while the output
//   register is empty or out_ready is high; this rate is set by the poll
//   state register feeding the decode logic straight back into itself
// reset (rst_n low, synchronous): select high, no pad, normal mode, no
//   skipped polls, button word zero, output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module six_button_pad_poller (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // poll request: sampled connector pins
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_pin1_level,
  input  wire logic        in_pin2_level,
  input  wire logic        in_pin3_level,
  input  wire logic        in_pin4_level,
  input  wire logic        in_pin6_level,
  input  wire logic        in_pin9_level,

  // result: button word and the select level to drive next
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [12:0] out_buttons,
  output      logic        out_select_next
);

  sbpp_pkg::state_t state_r;
  sbpp_pkg::state_t state_nxt;
  sbpp_pkg::pins_t  pins;

  logic             out_valid_r;
  sbpp_pkg::word_t  out_buttons_r;
  logic             out_select_next_r;
  logic             in_accept;

  // the output register frees up in the same cycle its result is taken,
  // so a new poll can enter while the previous result is being handed over
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_accept = in_valid & in_ready;

  assign pins.pin1 = in_pin1_level;
  assign pins.pin2 = in_pin2_level;
  assign pins.pin3 = in_pin3_level;
  assign pins.pin4 = in_pin4_level;
  assign pins.pin6 = in_pin6_level;
  assign pins.pin9 = in_pin9_level;

  // decode of one poll against the current pad state
  sbpp_update u_update (
    .cur  (state_r),
    .pins (pins),
    .nxt  (state_nxt)
  );

  // poll state only moves on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.select_level  <= 1'b1;
      state_r.pad_connected <= 1'b0;
      state_r.six_mode      <= 1'b0;
      state_r.skip_count    <= sbpp_pkg::SKIP_NONE;
      state_r.button_word   <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the post-poll word and select level
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_buttons_r     <= state_nxt.button_word;
      out_select_next_r <= state_nxt.select_level;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_buttons     = out_buttons_r;
  assign out_select_next = out_select_next_r;

endmodule

`default_nettype wire

// ===== design/sbpp_update.sv =====
// ----------------------------------------------------------------------------
// sbpp_update
// one-poll state update: select toggle, skip countdown, pad detect and button decode
// ----------------------------------------------------------------------------
`default_nettype none

module sbpp_update (
  input  sbpp_pkg::state_t cur,
  input  sbpp_pkg::pins_t  pins,
  output sbpp_pkg::state_t nxt
);

  logic sel;
  logic p1, p2, p3, p4, p6, p9;

  assign sel = ~cur.select_level;
  assign p1  = ~pins.pin1;
  assign p2  = ~pins.pin2;
  assign p3  = ~pins.pin3;
  assign p4  = ~pins.pin4;
  assign p6  = ~pins.pin6;
  assign p9  = ~pins.pin9;

  always_comb begin
    nxt              = cur;
    nxt.select_level = sel;
    if (cur.skip_count == sbpp_pkg::SKIP_NONE) begin
      if (sel) begin
        if (cur.pad_connected) begin
          if (cur.six_mode) begin
            nxt.button_word[sbpp_pkg::BTN_Z]    = p1;
            nxt.button_word[sbpp_pkg::BTN_Y]    = p2;
            nxt.button_word[sbpp_pkg::BTN_X]    = p3;
            nxt.button_word[sbpp_pkg::BTN_MODE] = p4;
            nxt.six_mode                        = 1'b0;
            nxt.skip_count                      = sbpp_pkg::SKIP_POLLS;
          end else begin
            nxt.button_word[sbpp_pkg::BTN_UP]    = p1;
            nxt.button_word[sbpp_pkg::BTN_DOWN]  = p2;
            nxt.button_word[sbpp_pkg::BTN_LEFT]  = p3;
            nxt.button_word[sbpp_pkg::BTN_RIGHT] = p4;
            nxt.button_word[sbpp_pkg::BTN_B]     = p6;
            nxt.button_word[sbpp_pkg::BTN_C]     = p9;
          end
        end else begin
          // two-button fallback rebuilds the whole word
          nxt.button_word                      = '0;
          nxt.button_word[sbpp_pkg::BTN_UP]    = p1;
          nxt.button_word[sbpp_pkg::BTN_DOWN]  = p2;
          nxt.button_word[sbpp_pkg::BTN_LEFT]  = p3;
          nxt.button_word[sbpp_pkg::BTN_RIGHT] = p4;
          nxt.button_word[sbpp_pkg::BTN_A]     = p6;
          nxt.button_word[sbpp_pkg::BTN_B]     = p9;
        end
      end else begin
        nxt.pad_connected = p3 & p4;
        nxt.six_mode      = p1 & p2;
        if (p3 && p4 && !(p1 && p2)) begin
          nxt.button_word[sbpp_pkg::BTN_A]     = p6;
          nxt.button_word[sbpp_pkg::BTN_START] = p9;
        end
      end
    end else begin
      if (cur.skip_count == sbpp_pkg::SKIP_POLLS) begin
        nxt.button_word[sbpp_pkg::BTN_HOME] = p1;
      end
      nxt.skip_count = cur.skip_count - 2'd1;
    end
  end

endmodule

`default_nettype wire
